/* sv/shis_pkg.sv */
// ----------------------------------------------------------------------------
// shis_pkg
// Types, codes and decode tables shared by the interrupt sequencer modules.
// ----------------------------------------------------------------------------
package shis_pkg;

    localparam int UNITS     = 8;
    localparam int REQ_DEPTH = 4;
    localparam int SQ_DEPTH  = 8;

    localparam int UNIT_W  = 3;
    localparam int COUNT_W = 24;
    localparam int BYTE_W  = 8;
    localparam int CMD_W   = 4;
    localparam int KIND_W  = 3;
    localparam int DFA_W   = 3;
    localparam int CLASS_W = 4;
    localparam int ACT_W   = 4;
    localparam int ENTRY_W = COUNT_W + 1;
    localparam int SLOT_W  = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1;
    localparam int PCNT_W  = $clog2(REQ_DEPTH + 1);
    localparam int ADDR_W  = (UNITS * REQ_DEPTH > 1) ? $clog2(UNITS * REQ_DEPTH) : 1;
    localparam int SQP_W   = $clog2(SQ_DEPTH);
    localparam int SQC_W   = $clog2(SQ_DEPTH + 1);

    typedef logic [UNIT_W-1:0]  unit_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [CMD_W-1:0]   cmd_t;
    typedef logic [KIND_W-1:0]  kind_t;
    typedef logic [DFA_W-1:0]   dfa_t;
    typedef logic [CLASS_W-1:0] class_t;
    typedef logic [ACT_W-1:0]   act_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    localparam kind_t KIND_START    = 3'd0;
    localparam kind_t KIND_RESUME44 = 3'd1;
    localparam kind_t KIND_RESUME45 = 3'd2;
    localparam kind_t KIND_END      = 3'd3;
    localparam kind_t KIND_DONE     = 3'd4;
    localparam kind_t KIND_ABORTED  = 3'd5;
    localparam kind_t KIND_DEAD     = 3'd6;
    localparam kind_t KIND_REJECT   = 3'd7;

    localparam dfa_t DFA_IDLE      = 3'd0;
    localparam dfa_t DFA_STARTING  = 3'd1;
    localparam dfa_t DFA_RESUMING  = 3'd2;
    localparam dfa_t DFA_DEAD      = 3'd3;
    localparam dfa_t DFA_MESSAGING = 3'd4;
    localparam dfa_t DFA_ENDING    = 3'd5;

    localparam act_t ACT_DONE       = 4'd0;
    localparam act_t ACT_DEAD       = 4'd1;
    localparam act_t ACT_RESEL_SAVE = 4'd2;
    localparam act_t ACT_RESEL      = 4'd3;
    localparam act_t ACT_RESTORE    = 4'd4;
    localparam act_t ACT_ABORT      = 4'd5;
    localparam act_t ACT_SAVE       = 4'd6;
    localparam act_t ACT_DISC       = 4'd7;
    localparam act_t ACT_MSG        = 4'd8;
    localparam act_t ACT_END        = 4'd9;

    localparam logic OP_QUEUE = 1'b0;

    localparam byte_t PHASE_OK        = 8'h60;
    localparam byte_t MSG_RESTORE     = 8'h03;
    localparam cmd_t  START_CMD_RESET = 4'd9;

    localparam act_t ACTION_TABLE [6][9] = '{
        '{ACT_DEAD, ACT_DEAD, ACT_DEAD, ACT_DEAD, ACT_RESEL, ACT_DEAD, ACT_DEAD,
          ACT_DEAD, ACT_DEAD},
        '{ACT_ABORT, ACT_DEAD, ACT_SAVE, ACT_DISC, ACT_RESEL_SAVE, ACT_MSG, ACT_DEAD,
          ACT_END, ACT_DONE},
        '{ACT_DEAD, ACT_DEAD, ACT_SAVE, ACT_DISC, ACT_DEAD, ACT_MSG, ACT_DEAD,
          ACT_END, ACT_DONE},
        '{ACT_DEAD, ACT_DEAD, ACT_DEAD, ACT_DEAD, ACT_DEAD, ACT_DEAD, ACT_DEAD,
          ACT_DEAD, ACT_DEAD},
        '{ACT_DEAD, ACT_DEAD, ACT_DEAD, ACT_DEAD, ACT_DEAD, ACT_DEAD, ACT_RESTORE,
          ACT_DEAD, ACT_DEAD},
        '{ACT_DEAD, ACT_DEAD, ACT_DEAD, ACT_DEAD, ACT_DEAD, ACT_DEAD, ACT_DEAD,
          ACT_DEAD, ACT_DONE}
    };

    function automatic class_t status_class(input byte_t ss);
        class_t c;
        unique case (ss)
            8'h42:   c = 4'd0;
            8'h21:   c = 4'd2;
            8'h85:   c = 4'd3;
            8'h81:   c = 4'd4;
            8'h4F:   c = 4'd5;
            8'h20:   c = 4'd6;
            8'h4B:   c = 4'd7;
            8'h16:   c = 4'd8;
            default: c = 4'd1;
        endcase
        return c;
    endfunction

    typedef struct packed {
        logic capture;
        logic exec;
        logic fetch;
        logic launch;
        logic fill;
    } ctl_cmd_t;

    typedef struct packed {
        logic need_start;
        logic start_emit;
    } ctl_stat_t;

endpackage

/* sv/shis_ctrl.sv */
// ----------------------------------------------------------------------------
// shis_ctrl
// Sequencing controller: steps each word through capture, execute, fetch and
// the optional start-queue service.
// ----------------------------------------------------------------------------
module shis_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output shis_pkg::ctl_cmd_t cmd,
    input  shis_pkg::ctl_stat_t stat
);
    import shis_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_FETCH = 5'b00100,
        S_START = 5'b01000,
        S_FILL  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = stat.need_start ? S_START : S_IDLE;
            end
            S_START:
            begin
                cmd.launch = 1'b1;
                state_next = stat.start_emit ? S_FILL : S_IDLE;
            end
            S_FILL:
            begin
                cmd.fill   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* sv/shis_datapath.sv */
// ----------------------------------------------------------------------------
// shis_datapath
// Interrupt DFA, unit FIFOs, request store, start queue and result registers.
// ----------------------------------------------------------------------------
module shis_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  shis_pkg::ctl_cmd_t   cmd,
    output shis_pkg::ctl_stat_t  stat,
    input  logic                 cfg_we,
    input  shis_pkg::cmd_t       cfg_data,
    input  logic                 action,
    input  shis_pkg::unit_t      unit,
    input  shis_pkg::count_t     byte_count,
    input  logic                 reading,
    input  shis_pkg::byte_t      scsi_status,
    input  shis_pkg::unit_t      source_id,
    input  shis_pkg::byte_t      phase,
    input  shis_pkg::byte_t      target_status,
    input  shis_pkg::count_t     remaining_count,
    input  shis_pkg::byte_t      message_byte,
    output logic                 result_valid,
    output shis_pkg::kind_t      kind,
    output shis_pkg::unit_t      unit_res,
    output shis_pkg::count_t     transfer_count,
    output logic                 reading_res,
    output shis_pkg::byte_t      scsi_command,
    output logic                 okay,
    output shis_pkg::byte_t      status_byte,
    output logic                 last
);
    import shis_pkg::*;

    // captured word
    logic   op_reg;
    unit_t  unit_in_reg;
    count_t count_in_reg;
    logic   rd_in_reg;
    byte_t  ss_reg;
    unit_t  src_reg;
    byte_t  phase_reg;
    byte_t  tstat_reg;
    count_t remain_reg;
    byte_t  msg_reg;

    // block state
    cmd_t              start_cmd_reg;
    dfa_t              dfa_reg, dfa_next;
    unit_t             cu_reg, cu_next;
    count_t            saved_reg [UNITS];
    logic [PCNT_W-1:0] pend_cnt_reg [UNITS];
    logic [SLOT_W-1:0] pend_head_reg [UNITS];
    unit_t             sq_mem [SQ_DEPTH];
    logic [SQP_W-1:0]  sq_head_reg, sq_head_next;
    logic [SQC_W-1:0]  sq_cnt_reg, sq_cnt_next;
    entry_t            req_mem [UNITS*REQ_DEPTH];
    entry_t            rd_data_reg;

    // first result
    logic  r1_valid_reg, r1_valid_next;
    kind_t r1_kind_reg, r1_kind_next;
    unit_t r1_unit_reg, r1_unit_next;
    logic  r1_rdv_reg, r1_rdv_next;
    logic  r1_ok_reg, r1_ok_next;
    byte_t r1_stat_reg, r1_stat_next;
    logic  need_start_reg, need_start_next;
    logic  start_emit_reg;

    // execute-step controls
    logic              push, pop_cu, wr_req, save_cnt, go_dead;
    unit_t             push_unit, rd_unit;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [SLOT_W:0]   slot_sum;
    logic [SLOT_W-1:0] wr_slot;
    act_t              act;
    dfa_t              st_idx;
    unit_t             sq_front;
    logic              start_ok, start_emit;

    function automatic logic [ADDR_W-1:0] req_addr(input unit_t u,
                                                   input logic [SLOT_W-1:0] s);
        return ADDR_W'(int'(u) * REQ_DEPTH + int'(s));
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (int'(s) + 1 >= REQ_DEPTH) ? '0 : SLOT_W'(int'(s) + 1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= action;
            unit_in_reg  <= unit;
            count_in_reg <= byte_count;
            rd_in_reg    <= reading;
            ss_reg       <= scsi_status;
            src_reg      <= source_id;
            phase_reg    <= phase;
            tstat_reg    <= target_status;
            remain_reg   <= remaining_count;
            msg_reg      <= message_byte;
        end
    end

    assign st_idx   = (dfa_reg > DFA_ENDING) ? DFA_DEAD : dfa_reg;
    assign act      = ACTION_TABLE[st_idx][status_class(ss_reg)];
    assign sq_front = sq_mem[sq_head_reg];
    assign start_ok   = (dfa_reg == DFA_IDLE) && (sq_cnt_reg != '0);
    assign start_emit = start_ok && (pend_cnt_reg[sq_front] != '0);

    assign slot_sum = {1'b0, pend_head_reg[unit_in_reg]}
                    + (SLOT_W+1)'(pend_cnt_reg[unit_in_reg]);
    assign wr_slot  = (int'(slot_sum) >= REQ_DEPTH) ? SLOT_W'(int'(slot_sum) - REQ_DEPTH)
                                                   : slot_sum[SLOT_W-1:0];
    assign wr_addr  = req_addr(unit_in_reg, wr_slot);

    always_comb
    begin
        dfa_next        = dfa_reg;
        cu_next         = cu_reg;
        r1_valid_next   = r1_valid_reg;
        r1_kind_next    = r1_kind_reg;
        r1_unit_next    = r1_unit_reg;
        r1_rdv_next     = r1_rdv_reg;
        r1_ok_next      = r1_ok_reg;
        r1_stat_next    = r1_stat_reg;
        need_start_next = need_start_reg;
        push            = 1'b0;
        push_unit       = cu_reg;
        pop_cu          = 1'b0;
        wr_req          = 1'b0;
        save_cnt        = 1'b0;
        go_dead         = 1'b0;
        rd_unit         = cu_reg;

        if (cmd.exec)
        begin
            r1_valid_next   = 1'b0;
            r1_kind_next    = KIND_DEAD;
            r1_unit_next    = cu_reg;
            r1_rdv_next     = 1'b0;
            r1_ok_next      = 1'b0;
            r1_stat_next    = '0;
            need_start_next = 1'b0;
            if (op_reg == OP_QUEUE)
            begin
                if (int'(unit_in_reg) >= UNITS || int'(pend_cnt_reg[unit_in_reg]) >= REQ_DEPTH)
                begin
                    r1_valid_next = 1'b1;
                    r1_kind_next  = KIND_REJECT;
                    r1_unit_next  = unit_in_reg;
                end
                else
                begin
                    wr_req = 1'b1;
                    if (pend_cnt_reg[unit_in_reg] == '0)
                    begin
                        push            = 1'b1;
                        push_unit       = unit_in_reg;
                        need_start_next = (sq_cnt_reg == '0);
                    end
                end
            end
            else
            begin
                unique case (act)
                    ACT_DONE, ACT_ABORT:
                    begin
                        if (pend_cnt_reg[cu_reg] == '0)
                        begin
                            go_dead = 1'b1;
                        end
                        else
                        begin
                            r1_valid_next   = 1'b1;
                            r1_kind_next    = (act == ACT_DONE) ? KIND_DONE : KIND_ABORTED;
                            r1_rdv_next     = 1'b1;
                            r1_ok_next      = (act == ACT_DONE) && (phase_reg == PHASE_OK);
                            r1_stat_next    = r1_ok_next ? tstat_reg : '0;
                            pop_cu          = 1'b1;
                            push            = (pend_cnt_reg[cu_reg] > PCNT_W'(1));
                            dfa_next        = DFA_IDLE;
                            need_start_next = 1'b1;
                        end
                    end
                    ACT_RESEL_SAVE, ACT_RESEL:
                    begin
                        push = (act == ACT_RESEL_SAVE);
                        if (int'(src_reg) >= UNITS || pend_cnt_reg[src_reg] == '0)
                        begin
                            go_dead = 1'b1;
                        end
                        else
                        begin
                            cu_next       = src_reg;
                            dfa_next      = DFA_RESUMING;
                            r1_valid_next = 1'b1;
                            r1_kind_next  = KIND_RESUME44;
                            r1_unit_next  = src_reg;
                            r1_rdv_next   = 1'b1;
                            rd_unit       = src_reg;
                        end
                    end
                    ACT_RESTORE, ACT_SAVE:
                    begin
                        save_cnt      = (act == ACT_SAVE);
                        dfa_next      = DFA_RESUMING;
                        r1_valid_next = 1'b1;
                        r1_kind_next  = KIND_RESUME45;
                        r1_rdv_next   = (pend_cnt_reg[cu_reg] != '0);
                    end
                    ACT_DISC:
                    begin
                        dfa_next        = DFA_IDLE;
                        need_start_next = 1'b1;
                    end
                    ACT_MSG:
                    begin
                        if (msg_reg == MSG_RESTORE)
                        begin
                            dfa_next = DFA_MESSAGING;
                        end
                        else
                        begin
                            go_dead = 1'b1;
                        end
                    end
                    ACT_END:
                    begin
                        dfa_next      = DFA_ENDING;
                        r1_valid_next = 1'b1;
                        r1_kind_next  = KIND_END;
                        r1_rdv_next   = (pend_cnt_reg[cu_reg] != '0);
                    end
                    default:
                    begin
                        go_dead = 1'b1;
                    end
                endcase
                if (go_dead)
                begin
                    dfa_next      = DFA_DEAD;
                    r1_valid_next = 1'b1;
                    r1_kind_next  = KIND_DEAD;
                    r1_unit_next  = cu_reg;
                    r1_rdv_next   = 1'b0;
                end
            end
        end

        if (cmd.launch && start_emit)
        begin
            cu_next  = sq_front;
            dfa_next = DFA_STARTING;
        end
    end

    assign rd_addr = cmd.launch ? req_addr(sq_front, pend_head_reg[sq_front])
                                : req_addr(rd_unit, pend_head_reg[rd_unit]);

    always_comb
    begin
        sq_head_next = sq_head_reg;
        sq_cnt_next  = sq_cnt_reg;
        if (push && int'(sq_cnt_reg) < SQ_DEPTH)
        begin
            sq_cnt_next = sq_cnt_reg + SQC_W'(1);
        end
        if (cmd.launch && start_ok)
        begin
            sq_head_next = sq_head_reg + SQP_W'(1);
            sq_cnt_next  = sq_cnt_reg - SQC_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_req)
        begin
            req_mem[wr_addr] <= {rd_in_reg, count_in_reg};
        end
        rd_data_reg <= req_mem[rd_addr];
        if (push && int'(sq_cnt_reg) < SQ_DEPTH)
        begin
            sq_mem[sq_head_reg + sq_cnt_reg[SQP_W-1:0]] <= push_unit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_cmd_reg  <= START_CMD_RESET;
            dfa_reg        <= DFA_IDLE;
            cu_reg         <= '0;
            sq_head_reg    <= '0;
            sq_cnt_reg     <= '0;
            r1_valid_reg   <= 1'b0;
            need_start_reg <= 1'b0;
            start_emit_reg <= 1'b0;
            for (int i = 0; i < UNITS; i++)
            begin
                saved_reg[i]     <= '0;
                pend_cnt_reg[i]  <= '0;
                pend_head_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                start_cmd_reg <= cfg_data;
            end
            dfa_reg        <= dfa_next;
            cu_reg         <= cu_next;
            sq_head_reg    <= sq_head_next;
            sq_cnt_reg     <= sq_cnt_next;
            r1_valid_reg   <= r1_valid_next;
            need_start_reg <= need_start_next;
            if (cmd.launch)
            begin
                start_emit_reg <= start_emit;
            end
            if (wr_req)
            begin
                pend_cnt_reg[unit_in_reg] <= pend_cnt_reg[unit_in_reg] + PCNT_W'(1);
            end
            if (pop_cu)
            begin
                pend_cnt_reg[cu_reg]  <= pend_cnt_reg[cu_reg] - PCNT_W'(1);
                pend_head_reg[cu_reg] <= slot_inc(pend_head_reg[cu_reg]);
            end
            if (save_cnt)
            begin
                saved_reg[cu_reg] <= remain_reg;
            end
            if (cmd.fill && start_emit_reg)
            begin
                saved_reg[cu_reg] <= rd_data_reg[COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        r1_kind_reg <= r1_kind_next;
        r1_unit_reg <= r1_unit_next;
        r1_rdv_reg  <= r1_rdv_next;
        r1_ok_reg   <= r1_ok_next;
        r1_stat_reg <= r1_stat_next;
    end

    // result word registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= (cmd.fetch && r1_valid_reg) || (cmd.fill && start_emit_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            kind           <= r1_kind_reg;
            unit_res       <= r1_unit_reg;
            transfer_count <= (r1_kind_reg == KIND_RESUME44 || r1_kind_reg == KIND_RESUME45)
                            ? saved_reg[r1_unit_reg] : '0;
            reading_res    <= r1_rdv_reg & rd_data_reg[COUNT_W];
            scsi_command   <= (r1_kind_reg <= KIND_END) ? BYTE_W'(start_cmd_reg) : '0;
            okay           <= r1_ok_reg;
            status_byte    <= r1_stat_reg;
            last           <= !(need_start_reg && start_emit);
        end
        else if (cmd.fill)
        begin
            kind           <= KIND_START;
            unit_res       <= cu_reg;
            transfer_count <= rd_data_reg[COUNT_W-1:0];
            reading_res    <= rd_data_reg[COUNT_W];
            scsi_command   <= BYTE_W'(start_cmd_reg);
            okay           <= 1'b0;
            status_byte    <= '0;
            last           <= 1'b1;
        end
    end

    assign stat.need_start = need_start_reg;
    assign stat.start_emit = start_emit;

endmodule

/* sv/scsi_host_interrupt_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// scsi_host_interrupt_sequencer_unit
// SCSI host adapter interrupt sequencer: request queueing and interrupt DFA.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. A word that needs no
// start-queue service holds busy through the execute and fetch steps; when
// the start queue is serviced busy also covers a start step, and a fill step
// when a unit is started. The fill step is there for the request store's
// registered read of the started unit's head request. Each result word is
// shown for one cycle on result_valid, registered together with its fields;
// there is no back-pressure, so the receiver must take every result as it
// appears. At most two results follow one word, the second from the fill
// step, and last marks the final one. cfg_ready is always high.
module scsi_host_interrupt_sequencer_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  shis_pkg::cmd_t    cfg_data,
    input  logic              action,
    input  shis_pkg::unit_t   unit,
    input  shis_pkg::count_t  byte_count,
    input  logic              reading,
    input  shis_pkg::byte_t   scsi_status,
    input  shis_pkg::unit_t   source_id,
    input  shis_pkg::byte_t   phase,
    input  shis_pkg::byte_t   target_status,
    input  shis_pkg::count_t  remaining_count,
    input  shis_pkg::byte_t   message_byte,
    output logic              result_valid,
    output shis_pkg::kind_t   kind,
    output shis_pkg::unit_t   unit_res,
    output shis_pkg::count_t  transfer_count,
    output logic              reading_res,
    output shis_pkg::byte_t   scsi_command,
    output logic              okay,
    output shis_pkg::byte_t   status_byte,
    output logic              last
);
    import shis_pkg::*;

    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    assign cfg_ready = 1'b1;

    shis_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    shis_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_valid & cfg_ready),
        .cfg_data        (cfg_data),
        .action          (action),
        .unit            (unit),
        .byte_count      (byte_count),
        .reading         (reading),
        .scsi_status     (scsi_status),
        .source_id       (source_id),
        .phase           (phase),
        .target_status   (target_status),
        .remaining_count (remaining_count),
        .message_byte    (message_byte),
        .result_valid    (result_valid),
        .kind            (kind),
        .unit_res        (unit_res),
        .transfer_count  (transfer_count),
        .reading_res     (reading_res),
        .scsi_command    (scsi_command),
        .okay            (okay),
        .status_byte     (status_byte),
        .last            (last)
    );

endmodule

/* sv/shis_checker.sv */
// ----------------------------------------------------------------------------
// shis_checker
// Port-level checks on the interrupt sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module shis_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              result_valid,
    input shis_pkg::kind_t   kind,
    input shis_pkg::count_t  transfer_count,
    input logic              reading_res,
    input shis_pkg::byte_t   scsi_command,
    input logic              okay,
    input shis_pkg::byte_t   status_byte,
    input logic              last
);
    import shis_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted word");

    a_pair_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> !result_valid)
        else $error("second result not separated from first");

    a_notice_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == KIND_DONE || kind == KIND_ABORTED ||
                         kind == KIND_DEAD || kind == KIND_REJECT)
        |-> scsi_command == '0 && transfer_count == '0)
        else $error("notice carries a command or count");

    a_status_okay: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !okay |-> status_byte == '0)
        else $error("status byte without okay");

    a_dead_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == KIND_DEAD || kind == KIND_REJECT) |-> !reading_res)
        else $error("dead or rejected notice carries direction");

endmodule

bind scsi_host_interrupt_sequencer_unit shis_checker u_shis_checker (.*);
